@@ design/bitmap_block_allocator_macros.svh @@
// Assertion macros for the bitmap block allocator.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BBA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BBA_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BBA_ASSERT(name, clk, rst_n, prop, msg)
`define BBA_ASSERT_RST(name, clk, prop, msg)
`endif
`endif

@@ design/bba_pkg.sv @@
// Types, constants and codes shared by the bitmap block allocator modules.
package bba_pkg;

  localparam int CAPACITY    = 32768;
  localparam int WORD_BITS   = 32;
  localparam int NWORDS      = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_W      = $clog2(WORD_BITS);
  localparam int ADDR_W      = $clog2(NWORDS);
  localparam int CFG_W       = 16;
  localparam int HI_W        = CFG_W - WORD_W;
  localparam int ID_W        = 15;
  localparam int IDX_W       = 15;
  localparam int CMD_W       = 2;
  localparam int STAT_W      = 2;
  localparam int CFG_ADDR_W  = 1;
  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;
  localparam int TOTAL_RST   = 32768;
  localparam int RESV_RST    = 0;

  localparam logic [CFG_ADDR_W-1:0] REG_TOTAL    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_RESERVED = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CFG_W-1:0]     cfg_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_FORMAT = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_FILL
  } op_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_FMT,
    S_RESP
  } state_e;

  typedef struct packed {
    op_e               op;
    addr_t             word;
    word_t             data;
    logic [WORD_W-1:0] bit_sel;
    cfg_t              bound;
  } unit_req_t;

  typedef struct packed {
    logic              found;
    logic [WORD_W-1:0] pos;
    word_t             wdata;
    logic              more;
  } unit_rsp_t;

  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    word_t wr_data;
  } ram_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    status_e          status;
  } result_t;

endpackage

@@ design/bitmap_block_allocator.sv @@
// Bitmap block allocator top level: configuration registers, ports and wiring.
// First-fit block allocator over a 32768-bit used bitmap held in a 1024 x 32 RAM.
// After reset the block runs a clearing pass before it takes its first request;
// configuration writes are taken meanwhile. An allocate reads one bitmap word per
// cycle through the single RAM read port and the shared word unit, scanning up to
// the first free bit (at most 1024 words). A format rewrites every word. One request is
// in work at a time; the result waits in an output register while the next request
// is taken.
module bitmap_block_allocator import bba_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [14:0] block_id
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // [1:0] cmd
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [14:0] block_index, [16:15] status
);

  cfg_t      total_q, reserved_q;
  cfg_t      limit;
  cfg_t      fmt_n;
  result_t   res;
  ram_req_t  ram_req;
  word_t     rd_data;
  unit_req_t unit_req;
  unit_rsp_t unit_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= CFG_W'(TOTAL_RST);
      reserved_q <= CFG_W'(RESV_RST);
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_TOTAL:    total_q    <= cfg_wdata_i;
        REG_RESERVED: reserved_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign limit = (total_q < CFG_W'(CAPACITY)) ? total_q : CFG_W'(CAPACITY);
  assign fmt_n = (reserved_q < limit) ? reserved_q : limit;

  bba_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  bba_word_unit u_unit (
    .req_i (unit_req),
    .rsp_o (unit_rsp)
  );

  bba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .cmd_i     (s_axis_tuser[CMD_W-1:0]),
    .id_i      (s_axis_tdata[ID_W-1:0]),
    .limit_i   (limit),
    .fmt_n_i   (fmt_n),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (res),
    .ram_o     (ram_req),
    .rd_data_i (rd_data),
    .unit_o    (unit_req),
    .unit_i    (unit_rsp)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - IDX_W - STAT_W){1'b0}}, res.status, res.index};

endmodule

@@ design/bba_ram.sv @@
// Bitmap word memory: one write port, one registered read port.
module bba_ram import bba_pkg::*; (
  input  logic     clk_i,
  input  ram_req_t req_i,
  output word_t    rd_data_o
);

  word_t mem [NWORDS];
  word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/bba_word_unit.sv @@
// Shared word unit: bound mask, first free bit search and word update.
module bba_word_unit import bba_pkg::*; (
  input  unit_req_t req_i,
  output unit_rsp_t rsp_o
);

  logic [HI_W-1:0]   hi;
  logic [WORD_W-1:0] lo;
  logic [HI_W-1:0]   word_ext;
  logic [HI_W-1:0]   word_nxt;
  word_t             mask;
  word_t             cand;
  cfg_t              nxt_base;

  always_comb begin
    hi       = req_i.bound[CFG_W-1:WORD_W];
    lo       = req_i.bound[WORD_W-1:0];
    word_ext = HI_W'(req_i.word);
    word_nxt = word_ext + HI_W'(1);
    nxt_base = {word_nxt, {WORD_W{1'b0}}};

    if (word_ext < hi) begin
      mask = '1;
    end else if (word_ext == hi) begin
      mask = (word_t'(1) << lo) - word_t'(1);
    end else begin
      mask = '0;
    end

    cand         = ~req_i.data & mask;
    rsp_o.found  = |cand;
    rsp_o.pos    = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        rsp_o.pos = WORD_W'(i);
      end
    end
    rsp_o.more = nxt_base < req_i.bound;

    case (req_i.op)
      OP_ALLOC: rsp_o.wdata = req_i.data | (word_t'(1) << rsp_o.pos);
      OP_FREE:  rsp_o.wdata = req_i.data & ~(word_t'(1) << req_i.bit_sel);
      OP_FILL:  rsp_o.wdata = mask;
      default:  rsp_o.wdata = req_i.data;
    endcase
  end

endmodule

@@ design/bba_ctrl.sv @@
// Sequencer: command decode, word scan, format sweep and result register.
`include "bitmap_block_allocator_macros.svh"
module bba_ctrl import bba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [ID_W-1:0]   id_i,
  input  cfg_t              limit_i,
  input  cfg_t              fmt_n_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output result_t           res_o,
  output ram_req_t          ram_o,
  input  word_t             rd_data_i,
  output unit_req_t         unit_o,
  input  unit_rsp_t         unit_i
);

  state_e            state_q, state_d;
  addr_t             word_q, word_d;
  logic [ID_W-1:0]   id_q, id_d;
  cfg_t              fmt_n_q, fmt_n_d;
  result_t           res_q, res_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;
  logic              load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      word_q      <= '0;
      fmt_n_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_q      <= word_d;
      fmt_n_q     <= fmt_n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  always_comb begin
    state_d        = state_q;
    word_d         = word_q;
    id_d           = id_q;
    fmt_n_d        = fmt_n_q;
    res_d          = res_q;
    s_ready_o      = 1'b0;
    load           = 1'b0;
    ram_o          = '0;
    unit_o.op      = OP_FILL;
    unit_o.word    = word_q;
    unit_o.data    = rd_data_i;
    unit_o.bit_sel = id_q[WORD_W-1:0];
    unit_o.bound   = limit_i;

    case (state_q)
      S_INIT, S_FMT: begin
        unit_o.op    = OP_FILL;
        unit_o.bound = fmt_n_q;
        ram_o.wr_en   = 1'b1;
        ram_o.wr_addr = word_q;
        ram_o.wr_data = unit_i.wdata;
        if (word_q == ADDR_W'(NWORDS - 1)) begin
          word_d = '0;
          if (state_q == S_INIT) begin
            state_d = S_IDLE;
          end else begin
            res_d   = '{index: '0, status: ST_OK};
            state_d = S_RESP;
          end
        end else begin
          word_d = word_q + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          id_d   = id_i;
          word_d = '0;
          case (cmd_i)
            CMD_ALLOC: begin
              ram_o.rd_en   = 1'b1;
              ram_o.rd_addr = '0;
              state_d       = S_ALLOC;
            end
            CMD_FREE: begin
              if (CFG_W'(id_i) >= limit_i) begin
                res_d   = '{index: '0, status: ST_RANGE};
                state_d = S_RESP;
              end else begin
                ram_o.rd_en   = 1'b1;
                ram_o.rd_addr = ADDR_W'(id_i >> WORD_W);
                state_d       = S_FREE;
              end
            end
            CMD_FORMAT: begin
              fmt_n_d = fmt_n_i;
              state_d = S_FMT;
            end
            default: begin
              res_d   = '{index: '0, status: ST_OK};
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_ALLOC: begin
        unit_o.op = OP_ALLOC;
        if (unit_i.found) begin
          ram_o.wr_en   = 1'b1;
          ram_o.wr_addr = word_q;
          ram_o.wr_data = unit_i.wdata;
          res_d         = '{index: IDX_W'({word_q, unit_i.pos}), status: ST_OK};
          state_d       = S_RESP;
        end else if (unit_i.more) begin
          word_d        = word_q + ADDR_W'(1);
          ram_o.rd_en   = 1'b1;
          ram_o.rd_addr = word_q + ADDR_W'(1);
        end else begin
          res_d   = '{index: '0, status: ST_FULL};
          state_d = S_RESP;
        end
      end
      S_FREE: begin
        unit_o.op     = OP_FREE;
        unit_o.word   = ADDR_W'(id_q >> WORD_W);
        ram_o.wr_en   = 1'b1;
        ram_o.wr_addr = ADDR_W'(id_q >> WORD_W);
        ram_o.wr_data = unit_i.wdata;
        res_d         = '{index: '0, status: ST_OK};
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || m_ready_i) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      out_d       = res_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign res_o     = out_q;

  `BBA_ASSERT_RST(a_rst_init, clk_i, (!rst_ni && $past(!rst_ni)) |-> state_q == S_INIT, "reset must hold the clear sweep")
  `BBA_ASSERT(a_alloc_one_bit, clk_i, rst_ni, (state_q == S_ALLOC && unit_i.found) |-> $onehot(ram_o.wr_data ^ rd_data_i), "allocate must set exactly one free bit")
  `BBA_ASSERT(a_free_resp, clk_i, rst_ni, state_q == S_FREE |=> state_q == S_RESP, "free must finish in one step")
  `BBA_ASSERT(a_full_zero, clk_i, rst_ni, (state_q == S_RESP && res_q.status != ST_OK) |-> res_q.index == '0, "failed request must return index zero")

endmodule
